FILE: hdl/velocity_key_matrix_scanner_macros.svh
// ============================================================================
// Assertion macros for the velocity key matrix scanner
// Concurrent property wrappers that compile to nothing in synthesis builds.
// ============================================================================
`ifndef VELOCITY_KEY_MATRIX_SCANNER_MACROS_SVH
`define VELOCITY_KEY_MATRIX_SCANNER_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define VKMS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vkms: same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define VKMS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vkms: next-cycle implication failed");

// The condition must hold at every clock edge out of reset.
`define VKMS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("vkms: invariant failed");

`else

`define VKMS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VKMS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`define VKMS_ASSERT_ALWAYS(label, clk, rst_n, cond)

`endif

`endif

FILE: hdl/vkms_pkg.sv
// ============================================================================
// Velocity key matrix scanner package
// Shared field widths, map and event codes, velocity constants and the types
// that travel between the front end, the back end and the top level.
// ============================================================================
package vkms_pkg;

    localparam int SLOT_W    = 4;
    localparam int LEVEL_W   = 8;
    localparam int TIME_W    = 32;
    localparam int ID_W      = 7;
    localparam int KIND_W    = 2;
    localparam int VEL_W     = 7;
    localparam int MAP_AW    = 7;
    localparam int MAP_DEPTH = 128;

    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = 4;

    // Input item modes.
    localparam logic MODE_SCAN = 1'b0;
    localparam logic MODE_MAP  = 1'b1;

    // Contact roles in the map.
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOP    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BOTTOM = 2'd3;

    // Event codes.
    localparam logic [KIND_W-1:0] EV_BTN_DOWN = 2'd0;
    localparam logic [KIND_W-1:0] EV_BTN_UP   = 2'd1;
    localparam logic [KIND_W-1:0] EV_NOTE_ON  = 2'd2;
    localparam logic [KIND_W-1:0] EV_NOTE_OFF = 2'd3;

    // Velocity curve: full scale below the fast limit, minimum above the slow
    // limit, linear in between. The slope 126/49500 reduces to 7/2750, and the
    // division by 2750 is a multiply by ceil(2^30/2750) that is exact over the
    // whole range of 7*(d-500).
    localparam int                VEL_FAST_US = 500;
    localparam int                VEL_SLOW_US = 50000;
    localparam logic [VEL_W-1:0]  VEL_MAX     = 7'd127;
    localparam logic [VEL_W-1:0]  VEL_MIN     = 7'd1;
    localparam int                VEL_OFF_W   = 16;
    localparam int                VEL_Y_W     = 19;
    localparam logic [VEL_Y_W-1:0] VEL_RECIP  = 19'd390452;
    localparam int                VEL_SHIFT   = 30;
    localparam int                VEL_PROD_W  = 2 * VEL_Y_W;

    typedef struct packed {
        logic                 is_map;
        logic [LEVEL_W-1:0]   column_levels;
        logic [TIME_W-1:0]    time_us;
        logic [MAP_AW-1:0]    map_index;
        logic [KIND_W-1:0]    map_kind;
        logic [ID_W-1:0]      map_id;
    } t_item;

    typedef struct packed {
        logic                 closed;
        logic [KIND_W-1:0]    kind;
        logic [ID_W-1:0]      id;
    } t_map_entry;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [ID_W-1:0]      id;
        logic [VEL_W-1:0]     vel;
    } t_event;

endpackage

FILE: hdl/vkms_ram.sv
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ============================================================================
module vkms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/vkms_front.sv
// ============================================================================
// Velocity key matrix scanner front end
// Accepts input items, tags them as scan ticks or map writes, and holds them
// in a two-entry queue until the back end takes them.
// ============================================================================
module vkms_front
    import vkms_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_mode,
    input  logic [LEVEL_W-1:0] i_column_levels,
    input  logic [TIME_W-1:0]  i_time_us,
    input  logic [MAP_AW-1:0]  i_map_index,
    input  logic [KIND_W-1:0]  i_map_kind,
    input  logic [ID_W-1:0]    i_map_id,
    output logic               o_item_valid,
    output t_item              o_item,
    input  logic               i_pop
);

    t_item       r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_count;
    logic        push;
    t_item       item;

    always_comb begin
        item.is_map        = (i_mode == MODE_MAP);
        item.column_levels = i_column_levels;
        item.time_us       = i_time_us;
        item.map_index     = i_map_index;
        item.map_kind      = i_map_kind;
        item.map_id        = i_map_id;
    end

    assign o_stall      = (r_count == 2'd2);
    assign push         = i_valid && !o_stall;
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + 2'(push) - 2'(i_pop);
        end
    end

endmodule

FILE: hdl/vkms_back.sv
// ============================================================================
// Velocity key matrix scanner back end
// Applies map writes, walks the columns of a scan tick one at a time against
// the contact map, tracks key top contacts, computes note velocity and emits
// events via a one-deep pending stage so the last event of a tick is marked.
// ============================================================================
`include "velocity_key_matrix_scanner_macros.svh"

module vkms_back
    import vkms_pkg::*;
#(
    parameter int COLUMN_COUNT = 8,
    parameter int SLOT_COUNT   = 16,
    parameter int KEY_COUNT    = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    input  t_item             i_item,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [KIND_W-1:0] o_event_kind,
    output logic [ID_W-1:0]   o_event_id,
    output logic [VEL_W-1:0]  o_velocity,
    output logic              o_last_event
);

    localparam int COL_W  = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
    localparam int KEY_AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int MAP_W  = $bits(t_map_entry);
    localparam int KEY_W  = TIME_W + 1;

    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMN_COUNT - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MRD  = 4'd1;
    localparam logic [3:0] S_MWR  = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_KEY  = 4'd5;
    localparam logic [3:0] S_VEL1 = 4'd6;
    localparam logic [3:0] S_VEL2 = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;
    localparam logic [3:0] S_END  = 4'd9;

    logic [3:0]            r_state;
    t_item                 r_item;
    logic [COL_W-1:0]      r_col;
    logic [SLOT_W-1:0]     r_slot;
    logic [MAP_DEPTH-1:0]  r_map_vld;
    logic [KEY_COUNT-1:0]  r_key_vld;
    logic                  r_map_rvld;
    logic                  r_key_rvld;
    logic [ID_W-1:0]       r_id;
    t_event                r_ev;
    logic                  r_pend_valid;
    t_event                r_pend;
    logic [CNT_W-1:0]      r_n;
    logic                  r_out_valid;
    t_event                r_out;
    logic                  r_out_last;
    logic [TIME_W-1:0]     r_dt;
    logic                  r_fast;
    logic                  r_slow;
    logic [VEL_PROD_W-1:0] r_prod;

    logic [2:0]            col_lo;
    logic [MAP_AW-1:0]     scan_idx;
    logic                  press;
    t_map_entry            ent;
    logic                  changed;
    logic                  id_ok;
    logic                  key_held;
    logic                  out_free;
    logic                  end_flush;
    logic                  out_load;
    logic [3:0]            adv_state;
    logic [VEL_OFF_W-1:0]  dt_off;
    logic [VEL_Y_W-1:0]    vel_y;
    logic [VEL_W-1:0]      vel;

    logic                  map_we;
    logic [MAP_AW-1:0]     map_waddr;
    t_map_entry            map_wdata;
    logic                  map_re;
    logic [MAP_AW-1:0]     map_raddr;
    logic [MAP_W-1:0]      map_rdata;

    logic                  key_we;
    logic                  key_re;
    logic [KEY_AW-1:0]     key_addr;
    logic [KEY_W-1:0]      key_rdata;

    // Matrix entry of the current column: column times 16 plus slot, wrapped.
    assign col_lo   = 3'(r_col);
    assign scan_idx = MAP_AW'({r_col, 4'b0000}) | {3'b000, r_slot};
    assign press    = (int'(r_col) < LEVEL_W) && !r_item.column_levels[col_lo];

    // Entries never written read as an open, unmapped contact.
    assign ent      = r_map_rvld ? t_map_entry'(map_rdata) : '0;
    assign changed  = (press != ent.closed);
    assign id_ok    = (int'(ent.id) < KEY_COUNT);
    assign key_held = r_key_rvld && key_rdata[TIME_W];
    assign out_free = !r_out_valid || !i_stall;
    assign adv_state = (r_col == COL_LAST) ? S_END : S_RD;

    // The pending event moves to the result register when a new event
    // replaces it or when the tick ends.
    assign end_flush = (r_state == S_END) && r_pend_valid && out_free;
    assign out_load  = end_flush || ((r_state == S_EMIT) && (r_n != CNT_W'(MAX_RESULTS))
                                     && r_pend_valid && out_free);

    assign dt_off = VEL_OFF_W'(r_dt - TIME_W'(VEL_FAST_US));
    assign vel_y  = {dt_off, 3'b000} - {3'b000, dt_off};
    assign vel    = r_fast ? VEL_MAX :
                    r_slow ? VEL_MIN :
                    VEL_MAX - r_prod[VEL_SHIFT +: VEL_W];

    always_comb begin
        map_re    = (r_state == S_MRD) || (r_state == S_RD);
        map_raddr = (r_state == S_MRD) ? r_item.map_index : scan_idx;
        map_we    = (r_state == S_MWR) || ((r_state == S_CHK) && changed);
        if (r_state == S_MWR) begin
            map_waddr        = r_item.map_index;
            map_wdata.closed = ent.closed;
            map_wdata.kind   = r_item.map_kind;
            map_wdata.id     = r_item.map_id;
        end else begin
            map_waddr        = scan_idx;
            map_wdata.closed = press;
            map_wdata.kind   = ent.kind;
            map_wdata.id     = ent.id;
        end
    end

    assign key_addr = KEY_AW'(ent.id);
    assign key_we   = (r_state == S_CHK) && changed && (ent.kind == KIND_TOP) && id_ok;
    assign key_re   = (r_state == S_CHK) && changed && (ent.kind == KIND_BOTTOM) && id_ok
                      && press;

    vkms_ram #(
        .WIDTH (MAP_W),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    // Per key: top contact held flag and the time the top contact last changed.
    vkms_ram #(
        .WIDTH (KEY_W),
        .DEPTH (KEY_COUNT)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_addr),
        .i_wdata ({press, r_item.time_us}),
        .i_re    (key_re),
        .i_raddr (key_addr),
        .o_rdata (key_rdata)
    );

    assign o_pop = (r_state == S_IDLE) && i_item_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_col        <= '0;
            r_slot       <= '0;
            r_map_vld    <= '0;
            r_key_vld    <= '0;
            r_map_rvld   <= 1'b0;
            r_key_rvld   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_n          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= out_load || (r_out_valid && i_stall);
            if (map_we) begin
                r_map_vld[map_waddr] <= 1'b1;
            end
            if (key_we) begin
                r_key_vld[key_addr] <= 1'b1;
            end
            if (map_re) begin
                r_map_rvld <= r_map_vld[map_raddr];
            end
            if (key_re) begin
                r_key_rvld <= r_key_vld[key_addr];
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_item  <= i_item;
                        r_col   <= '0;
                        r_n     <= '0;
                        r_state <= i_item.is_map ? S_MRD : S_RD;
                    end
                end
                S_MRD: begin
                    r_state <= S_MWR;
                end
                S_MWR: begin
                    r_state <= S_IDLE;
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_id <= ent.id;
                    if (changed && (ent.kind == KIND_BUTTON)) begin
                        r_ev.kind <= press ? EV_BTN_DOWN : EV_BTN_UP;
                        r_ev.id   <= ent.id;
                        r_ev.vel  <= '0;
                        r_state   <= S_EMIT;
                    end else if (changed && (ent.kind == KIND_TOP) && id_ok && !press) begin
                        r_ev.kind <= EV_NOTE_OFF;
                        r_ev.id   <= ent.id;
                        r_ev.vel  <= '0;
                        r_state   <= S_EMIT;
                    end else if (key_re) begin
                        r_state <= S_KEY;
                    end else begin
                        r_col   <= r_col + 1'b1;
                        r_state <= adv_state;
                    end
                end
                S_KEY: begin
                    r_dt <= r_item.time_us - key_rdata[TIME_W-1:0];
                    if (key_held) begin
                        r_state <= S_VEL1;
                    end else begin
                        r_col   <= r_col + 1'b1;
                        r_state <= adv_state;
                    end
                end
                S_VEL1: begin
                    r_fast  <= (r_dt < TIME_W'(VEL_FAST_US));
                    r_slow  <= (r_dt > TIME_W'(VEL_SLOW_US));
                    r_prod  <= VEL_PROD_W'(vel_y) * VEL_PROD_W'(VEL_RECIP);
                    r_state <= S_VEL2;
                end
                S_VEL2: begin
                    r_ev.kind <= EV_NOTE_ON;
                    r_ev.id   <= r_id;
                    r_ev.vel  <= vel;
                    r_state   <= S_EMIT;
                end
                S_EMIT: begin
                    // Events past the per-tick limit are dropped; the contact
                    // state has already been updated.
                    if (r_n == CNT_W'(MAX_RESULTS)) begin
                        r_col   <= r_col + 1'b1;
                        r_state <= adv_state;
                    end else if (!r_pend_valid) begin
                        r_pend       <= r_ev;
                        r_pend_valid <= 1'b1;
                        r_n          <= r_n + 1'b1;
                        r_col        <= r_col + 1'b1;
                        r_state      <= adv_state;
                    end else if (out_free) begin
                        r_out        <= r_pend;
                        r_out_last   <= 1'b0;
                        r_pend       <= r_ev;
                        r_n          <= r_n + 1'b1;
                        r_col        <= r_col + 1'b1;
                        r_state      <= adv_state;
                    end
                end
                S_END: begin
                    if (!r_pend_valid || out_free) begin
                        if (r_pend_valid) begin
                            r_out        <= r_pend;
                            r_out_last   <= 1'b1;
                            r_pend_valid <= 1'b0;
                        end
                        r_slot  <= (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_event_kind = r_out.kind;
    assign o_event_id   = r_out.id;
    assign o_velocity   = r_out.vel;
    assign o_last_event = r_out_last;

    `VKMS_ASSERT_IMP(a_pend_empty_idle, i_clk, i_rst_n, r_state == S_IDLE, !r_pend_valid)
    `VKMS_ASSERT_NXT(a_last_flush, i_clk, i_rst_n, end_flush, r_out_valid && r_out_last && !r_pend_valid)
    `VKMS_ASSERT_IMP(a_vel_note_on, i_clk, i_rst_n, r_out_valid, (r_out.kind == EV_NOTE_ON) == (r_out.vel != '0))
    `VKMS_ASSERT_ALWAYS(a_result_cap, i_clk, i_rst_n, r_n <= CNT_W'(MAX_RESULTS))

endmodule

FILE: hdl/velocity_key_matrix_scanner.sv
// ============================================================================
// Velocity key matrix scanner
// Scans a slot by column contact matrix and turns contact changes into button
// and velocity-sensitive note events, driven by a loadable contact map.
// ============================================================================
// Items enter a two-deep queue and are handled one at a time by the column
// sequencer. A map write reads the addressed entry and then writes it back
// with the new kind and id, keeping its contact state. A scan tick reads and
// checks each column's map entry, with an extra step per event, a key-time
// lookup per bottom contact press of a mapped key and the two-stage velocity
// multiply per note on. The contact map and key-time memories each have one
// read and one write port, which is why each column has a read state and a
// check state. The last event of a tick is held back until the tick ends so
// it can carry the last_event flag, and while the consumer stalls the result
// register the tick waits. The map resets to no-contact through per-entry
// valid bits, so no clearing pass is needed after reset.
module velocity_key_matrix_scanner
    import vkms_pkg::*;
#(
    parameter int COLUMN_COUNT = 8,
    parameter int SLOT_COUNT   = 16,
    parameter int KEY_COUNT    = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_mode,
    input  logic [LEVEL_W-1:0] i_column_levels,
    input  logic [TIME_W-1:0]  i_time_us,
    input  logic [MAP_AW-1:0]  i_map_index,
    input  logic [KIND_W-1:0]  i_map_kind,
    input  logic [ID_W-1:0]    i_map_id,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [KIND_W-1:0]  o_event_kind,
    output logic [ID_W-1:0]    o_event_id,
    output logic [VEL_W-1:0]   o_velocity,
    output logic               o_last_event
);

    logic  item_valid;
    t_item item;
    logic  pop;

    vkms_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_column_levels (i_column_levels),
        .i_time_us       (i_time_us),
        .i_map_index     (i_map_index),
        .i_map_kind      (i_map_kind),
        .i_map_id        (i_map_id),
        .o_item_valid    (item_valid),
        .o_item          (item),
        .i_pop           (pop)
    );

    vkms_back #(
        .COLUMN_COUNT (COLUMN_COUNT),
        .SLOT_COUNT   (SLOT_COUNT),
        .KEY_COUNT    (KEY_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_event_kind (o_event_kind),
        .o_event_id   (o_event_id),
        .o_velocity   (o_velocity),
        .o_last_event (o_last_event)
    );

endmodule
